// ===== rtl/pot_pkg.sv =====
// Shared types and constants for the polygon overlap test.
// Used by the channel interfaces, the edge unit, the top level and the checker.
package pot_pkg;

  // Width of the beat type code and of the hit side code.
  localparam int unsigned KIND_W = 2;
  localparam int unsigned SIDE_W = 2;

  // Input beat type codes.
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // Hit side codes of a result beat.
  localparam logic [SIDE_W-1:0] SIDE_NONE   = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_A_IN_B = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_B_IN_A = 2'd2;

  // Control from the sequencer to the edge unit.
  typedef struct packed {
    logic valid;  // an edge is presented this cycle
    logic clear;  // restart the crossing parity for a new point
  } edge_ctrl_t;

  // Status from the edge unit back to the sequencer.
  typedef struct packed {
    logic busy;    // edges still in flight
    logic parity;  // odd number of counted crossings so far
  } edge_stat_t;

endpackage

// ===== rtl/pot_in_if.sv =====
// Input channel of the polygon overlap test: valid/ready plus one item.
// Depends on pot_pkg for the beat type width.
interface pot_in_if import pot_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic        [KIND_W-1:0]     kind;
  logic                         start_new;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS:0]   offset_x;
  logic signed [COORD_BITS:0]   offset_y;

  modport source (
    output valid, kind, start_new, vertex_x, vertex_y, offset_x, offset_y,
    input  ready
  );
  modport sink (
    input  valid, kind, start_new, vertex_x, vertex_y, offset_x, offset_y,
    output ready
  );
endinterface

// ===== rtl/pot_out_if.sv =====
// Result channel of the polygon overlap test: valid/ready plus one result.
// Depends on pot_pkg for the hit side width.
interface pot_out_if import pot_pkg::*;;
  logic              valid;
  logic              ready;
  logic              overlap;
  logic [SIDE_W-1:0] hit_side;

  modport source (output valid, overlap, hit_side, input ready);
  modport sink (input valid, overlap, hit_side, output ready);
endinterface

// ===== rtl/pot_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module pot_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pot_edge_unit.sv =====
// Pipelined edge crossing unit: one polygon edge against the current point
// per cycle, exact cross product sign, even-odd parity. Depends on pot_pkg.
module pot_edge_unit import pot_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  edge_ctrl_t                   ctrl_i,
  input  logic [2*COORD_BITS-1:0]      vtx_i_i,
  input  logic [2*COORD_BITS-1:0]      vtx_j_i,
  input  logic signed [COORD_BITS+1:0] px_i,
  input  logic signed [COORD_BITS+1:0] py_i,
  output edge_stat_t                   stat_o
);

  localparam int unsigned DW  = COORD_BITS + 3;  // point relative differences
  localparam int unsigned EW  = COORD_BITS + 1;  // edge deltas
  localparam int unsigned PRW = DW + EW;         // one product
  localparam int unsigned SW  = PRW + 1;         // sum of both products

  logic signed [DW-1:0]  xi, yi, xj, yj, pxe, pye;
  logic signed [DW-1:0]  a_d, c_d, b_w, e_w;
  logic                  cross_d, dpos_d;

  logic                  v1_q, v2_q, parity_q;
  logic signed [DW-1:0]  a_q, c_q;
  logic signed [EW-1:0]  b_q, e_q;
  logic                  cross1_q, dpos1_q, cross2_q, dpos2_q;
  logic signed [PRW-1:0] p_d, q_d, p_q, q_q;
  logic signed [SW-1:0]  sum;
  logic                  hit;

  // Stage one: unpack the end points and form the differences.
  always_comb begin
    xi  = DW'($signed(vtx_i_i[COORD_BITS-1:0]));
    yi  = DW'($signed(vtx_i_i[2*COORD_BITS-1:COORD_BITS]));
    xj  = DW'($signed(vtx_j_i[COORD_BITS-1:0]));
    yj  = DW'($signed(vtx_j_i[2*COORD_BITS-1:COORD_BITS]));
    pxe = DW'(px_i);
    pye = DW'(py_i);
    a_d = xi - pxe;
    c_d = pye - yi;
    b_w = yj - yi;
    e_w = xj - xi;
    // The edge straddles the ray when exactly one end lies above it.
    cross_d = (yi > pye) != (yj > pye);
    dpos_d  = yj > yi;
  end

  // Stage two: the two products of the cross product.
  assign p_d = a_q * b_q;
  assign q_d = c_q * e_q;

  // Stage three: sign of the sum decides whether the crossing is to the right.
  always_comb begin
    sum = SW'(p_q) + SW'(q_q);
    hit = cross2_q && (dpos2_q ? !sum[SW-1] : (sum[SW-1] || (sum == '0)));
  end

  // Valid bits and the crossing parity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.valid;
      v2_q <= v1_q;
      if (ctrl_i.clear) begin
        parity_q <= 1'b0;
      end else if (v2_q && hit) begin
        parity_q <= !parity_q;
      end
    end
  end

  // Payload pipeline registers.
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    c_q      <= c_d;
    b_q      <= b_w[EW-1:0];
    e_q      <= e_w[EW-1:0];
    cross1_q <= cross_d;
    dpos1_q  <= dpos_d;
    p_q      <= p_d;
    q_q      <= q_d;
    cross2_q <= cross1_q;
    dpos2_q  <= dpos1_q;
  end

  assign stat_o.busy   = v1_q | v2_q;
  assign stat_o.parity = parity_q;

endmodule

// ===== rtl/polygon_overlap_test.sv =====
// Polygon overlap test. A load beat is taken while idle and the block stays ready for the next item.
// A query walks one edge per cycle, and per point adds a fetch, a load, the first vertex
// read, the closing edge and a drain of the edge unit. Search stops on the first hit.
// No new item is taken during a query, and a finished query waits while the result is stalled.
// Reset (asynchronous, active low) clears both vertex counts and the control state.
module polygon_overlap_test import pot_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pot_in_if.sink   in_i,
  pot_out_if.source out_o
);

  localparam int unsigned IDX_W   = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned ENTRY_W = 2 * COORD_BITS;
  localparam int unsigned PT_W    = COORD_BITS + 2;
  localparam int unsigned OFF_W   = COORD_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PT_RD,
    ST_PT_LD,
    ST_FIRST,
    ST_EDGE,
    ST_CLOSE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic                     pass_q, pass_d;
  logic [CNT_W-1:0]         cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0]         pt_idx_q, pt_idx_d, edge_idx_q, edge_idx_d;
  logic signed [OFF_W-1:0]  off_x_q, off_x_d, off_y_q, off_y_d;
  logic signed [PT_W-1:0]   px_q, px_d, py_q, py_d;
  logic [ENTRY_W-1:0]       first_q, first_d, prev_q, prev_d;
  logic [SIDE_W-1:0]        side_q, side_d;
  logic                     out_valid_q, out_valid_d, out_overlap_q, out_overlap_d;
  logic [SIDE_W-1:0]        out_side_q, out_side_d;

  logic                     in_accept;
  logic [CNT_W-1:0]         cnt_base;
  logic                     room;
  logic                     we_a, we_b;
  logic [IDX_W-1:0]         waddr, raddr;
  logic [ENTRY_W-1:0]       wdata, rd_a, rd_b, pt_data, poly_data;
  logic [CNT_W-1:0]         n_pt, n_poly;
  logic signed [PT_W-1:0]   vx_ext, vy_ext, ox_ext, oy_ext;
  edge_ctrl_t               edge_ctrl;
  edge_stat_t               edge_stat;
  logic [ENTRY_W-1:0]       edge_j;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  // Vertex load: optional restart of the count, then a write if there is room.
  always_comb begin
    if (in_i.kind == KIND_LOAD_A) begin
      cnt_base = in_i.start_new ? '0 : cnt_a_q;
    end else begin
      cnt_base = in_i.start_new ? '0 : cnt_b_q;
    end
    room  = cnt_base < CNT_W'(MAX_VERTICES);
    waddr = cnt_base[IDX_W-1:0];
    wdata = {in_i.vertex_y, in_i.vertex_x};
    we_a  = in_accept && (in_i.kind == KIND_LOAD_A) && room;
    we_b  = in_accept && (in_i.kind == KIND_LOAD_B) && room;
  end

  // The point store and the polygon store swap roles between the two passes.
  always_comb begin
    pt_data   = pass_q ? rd_b : rd_a;
    poly_data = pass_q ? rd_a : rd_b;
    n_pt      = pass_q ? cnt_b_q : cnt_a_q;
    n_poly    = pass_q ? cnt_a_q : cnt_b_q;
  end

  // Point in the frame of the polygon store.
  always_comb begin
    vx_ext = PT_W'($signed(pt_data[COORD_BITS-1:0]));
    vy_ext = PT_W'($signed(pt_data[ENTRY_W-1:COORD_BITS]));
    ox_ext = PT_W'(off_x_q);
    oy_ext = PT_W'(off_y_q);
  end

  pot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VERTICES)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  pot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VERTICES)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  // The closing edge runs from the last vertex back to the first.
  assign edge_j = (state_q == ST_CLOSE) ? first_q : poly_data;

  pot_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (edge_ctrl),
    .vtx_i_i (prev_q),
    .vtx_j_i (edge_j),
    .px_i    (px_q),
    .py_i    (py_q),
    .stat_o  (edge_stat)
  );

  // Sequencer: walks the points of one store against the edges of the other.
  always_comb begin
    state_d       = state_q;
    pass_d        = pass_q;
    cnt_a_d       = cnt_a_q;
    cnt_b_d       = cnt_b_q;
    pt_idx_d      = pt_idx_q;
    edge_idx_d    = edge_idx_q;
    off_x_d       = off_x_q;
    off_y_d       = off_y_q;
    px_d          = px_q;
    py_d          = py_q;
    first_d       = first_q;
    prev_d        = prev_q;
    side_d        = side_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_overlap_d = out_overlap_q;
    out_side_d    = out_side_q;
    raddr         = pt_idx_q[IDX_W-1:0];
    edge_ctrl     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_i.kind == KIND_LOAD_A) begin
            cnt_a_d = cnt_base + CNT_W'(room);
          end else if (in_i.kind == KIND_LOAD_B) begin
            cnt_b_d = cnt_base + CNT_W'(room);
          end else if (in_i.kind == KIND_QUERY) begin
            off_x_d  = in_i.offset_x;
            off_y_d  = in_i.offset_y;
            pass_d   = 1'b0;
            pt_idx_d = '0;
            side_d   = SIDE_NONE;
            state_d  = ST_PT_RD;
          end
        end
      end
      ST_PT_RD: begin
        // Fetch the next point, or move on to the next pass.
        raddr = pt_idx_q[IDX_W-1:0];
        if ((pt_idx_q < n_pt) && (n_poly != '0)) begin
          state_d = ST_PT_LD;
        end else if (!pass_q) begin
          pass_d   = 1'b1;
          pt_idx_d = '0;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PT_LD: begin
        px_d           = pass_q ? (vx_ext - ox_ext) : (vx_ext + ox_ext);
        py_d           = pass_q ? (vy_ext - oy_ext) : (vy_ext + oy_ext);
        raddr          = '0;
        edge_idx_d     = CNT_W'(1);
        edge_ctrl.clear = 1'b1;
        state_d        = ST_FIRST;
      end
      ST_FIRST: begin
        first_d = poly_data;
        prev_d  = poly_data;
        raddr   = edge_idx_q[IDX_W-1:0];
        if (n_poly == CNT_W'(1)) begin
          state_d = ST_CLOSE;
        end else begin
          edge_idx_d = edge_idx_q + CNT_W'(1);
          state_d    = ST_EDGE;
        end
      end
      ST_EDGE: begin
        // One edge per cycle from the previous vertex to the one just read.
        edge_ctrl.valid = 1'b1;
        prev_d          = poly_data;
        raddr           = edge_idx_q[IDX_W-1:0];
        if (edge_idx_q == n_poly) begin
          state_d = ST_CLOSE;
        end else begin
          edge_idx_d = edge_idx_q + CNT_W'(1);
        end
      end
      ST_CLOSE: begin
        edge_ctrl.valid = 1'b1;
        state_d         = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!edge_stat.busy) begin
          if (edge_stat.parity) begin
            side_d  = pass_q ? SIDE_B_IN_A : SIDE_A_IN_B;
            state_d = ST_DONE;
          end else begin
            pt_idx_d = pt_idx_q + CNT_W'(1);
            state_d  = ST_PT_RD;
          end
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_overlap_d = (side_q != SIDE_NONE);
          out_side_d    = side_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, counts and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pass_q        <= 1'b0;
      cnt_a_q       <= '0;
      cnt_b_q       <= '0;
      pt_idx_q      <= '0;
      edge_idx_q    <= '0;
      side_q        <= SIDE_NONE;
      out_valid_q   <= 1'b0;
      out_overlap_q <= 1'b0;
      out_side_q    <= SIDE_NONE;
    end else begin
      state_q       <= state_d;
      pass_q        <= pass_d;
      cnt_a_q       <= cnt_a_d;
      cnt_b_q       <= cnt_b_d;
      pt_idx_q      <= pt_idx_d;
      edge_idx_q    <= edge_idx_d;
      side_q        <= side_d;
      out_valid_q   <= out_valid_d;
      out_overlap_q <= out_overlap_d;
      out_side_q    <= out_side_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    off_x_q       <= off_x_d;
    off_y_q       <= off_y_d;
    px_q          <= px_d;
    py_q          <= py_d;
    first_q       <= first_d;
    prev_q        <= prev_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.overlap  = out_overlap_q;
  assign out_o.hit_side = out_side_q;

endmodule

// ===== rtl/pot_checker.sv =====
// Port level checks for the polygon overlap test, bound to the top level.
// Depends on pot_pkg for the beat type and hit side codes.
module pot_checker import pot_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [KIND_W-1:0] in_kind_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_overlap_i,
  input logic [SIDE_W-1:0] out_hit_side_i
);

  // The overlap flag agrees with the reported side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_overlap_i == (out_hit_side_i != SIDE_NONE)))
    else $error("overlap flag disagrees with hit side");

  // Only defined side codes are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_hit_side_i == SIDE_NONE || out_hit_side_i == SIDE_A_IN_B ||
                     out_hit_side_i == SIDE_B_IN_A))
    else $error("undefined hit side code");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_overlap_i) && $stable(out_hit_side_i)))
    else $error("result beat changed while stalled");

  // A query keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i == KIND_QUERY)) |=> !in_ready_i)
    else $error("input ready right after a query");

  // After any other beat the block is ready again in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i != KIND_QUERY)) |=> in_ready_i)
    else $error("input not ready after a load");

endmodule

bind polygon_overlap_test pot_checker u_pot_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_kind_i      (in_i.kind),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_overlap_i  (out_o.overlap),
  .out_hit_side_i (out_o.hit_side)
);
